// ----- sv/cifr_pkg.sv -----
`default_nettype none

package cifr_pkg;

    // Longest pattern and replacement, and the depth of the pending window.
    localparam int PatternMax = 16;
    localparam int Depth      = 16;
    localparam int CharW      = 8;
    localparam int CntW       = $clog2(Depth + 1);
    localparam int IdxW       = $clog2(Depth);
    localparam int CfgW       = 64;
    localparam int CfgIdxW    = 3;
    localparam int LenW       = 5;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_RPL_LO  = 3'd3,
        REG_RPL_HI  = 3'd4,
        REG_RPL_LEN = 3'd5
    } t_cfg_reg;

    // Where the emitter takes its characters from.
    typedef enum logic [1:0] {
        SRC_WINDOW,
        SRC_REPL,
        SRC_MARK
    } t_src;

    typedef logic [Depth-1:0][CharW-1:0] t_chars;

    typedef struct packed {
        logic [CharW-1:0] in_char;
        logic             in_last;
    } t_in;

    typedef struct packed {
        logic [CharW-1:0] out_char;
        logic             out_valid;
        logic             out_last;
    } t_out;

    typedef struct packed {
        t_src            kind;
        logic [IdxW-1:0] idx;
        logic [CntW-1:0] left;
        logic            last;
    } t_job;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // ASCII upper case folds to lower case; every other byte is left alone.
    function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] ch);
        logic [CharW-1:0] res;
        res = ch;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            res = ch + 8'h20;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/cifr_cell.sv -----
`default_nettype none

module cifr_cell
    import cifr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CharW-1:0] i_char,
    input  wire logic [CharW-1:0] i_char_prev,
    input  wire logic             i_alive_prev,
    input  wire logic [CharW-1:0] i_pat_char,
    input  wire logic             i_keep,
    output logic      [CharW-1:0] o_char,
    output logic                  o_alive,
    output logic                  o_alive_next
);

    logic [CharW-1:0] r_char;
    logic             r_alive;
    logic             n_alive;

    // A partial match one character longer survives if the new character fits here.
    assign o_alive_next = i_alive_prev && (fold_case(i_char) == fold_case(i_pat_char));

    always_comb begin
        n_alive = r_alive;
        if (i_ctl.clear) begin
            n_alive = 1'b0;
        end else if (i_ctl.shift) begin
            n_alive = o_alive_next && i_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else begin
            r_alive <= n_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_char <= i_char_prev;
        end
    end

    assign o_char  = r_char;
    assign o_alive = r_alive;

endmodule

`default_nettype wire

// ----- sv/cifr_emit.sv -----
`default_nettype none

module cifr_emit
    import cifr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_job   i_job,
    input  wire t_chars i_line,
    input  wire t_chars i_repl,
    output logic        o_ready,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_out        o_data
);

    t_src            r_kind;
    logic [IdxW-1:0] r_idx;
    logic [CntW-1:0] r_left;
    logic            r_last;
    t_chars          r_buf;
    t_out            r_out;
    logic            r_out_full;

    logic busy;
    logic out_free;
    logic step;
    t_out elem;

    assign busy     = (r_left != '0);
    assign out_free = !r_out_full || !i_stall;
    assign step     = busy && out_free;
    assign o_ready  = !busy || (step && r_left == CntW'(1));

    always_comb begin
        elem.out_valid = 1'b1;
        elem.out_last  = r_last && (r_left == CntW'(1));
        case (r_kind)
            SRC_WINDOW: elem.out_char = r_buf[r_idx];
            SRC_REPL:   elem.out_char = i_repl[r_idx];
            default: begin
                elem.out_char  = '0;
                elem.out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= SRC_WINDOW;
            r_idx      <= '0;
            r_left     <= '0;
            r_last     <= 1'b0;
            r_out_full <= 1'b0;
        end else begin
            if (i_load) begin
                r_kind <= i_job.kind;
                r_idx  <= i_job.idx;
                r_left <= i_job.left;
                r_last <= i_job.last;
            end else if (step) begin
                r_left <= r_left - CntW'(1);
                if (r_kind == SRC_WINDOW) begin
                    r_idx <= r_idx - IdxW'(1);
                end else begin
                    r_idx <= r_idx + IdxW'(1);
                end
            end
            if (step) begin
                r_out_full <= 1'b1;
            end else if (!i_stall) begin
                r_out_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_line;
        end
        if (step) begin
            r_out <= elem;
        end
    end

    assign o_valid = r_out_full;
    assign o_data  = r_out;

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("job loaded while the previous one still had results to give");

    a_left_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_load) |=> (r_left == $past(r_left) - CntW'(1)))
        else $error("result count did not fall by one after a result was issued");

    a_job_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_job.left != '0 && i_job.left <= CntW'(Depth)))
        else $error("job with no results or more results than the window holds");

endmodule

`default_nettype wire

// ----- sv/case_insensitive_find_replace.sv -----
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------
// input     | in        | i_valid / o_stall  | i_data: in_char, in_last
// output    | out       | o_valid / i_stall  | o_data: out_char, out_valid, out_last
// config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A request that produces at most one result is taken every cycle while the output is
// not stalled. A request that produces more results holds the input until the emitter
// has handed them all out from its single output register, one result per cycle unless stalled.
// Reset is synchronous and active low; it clears the registers and the window count.
// The window characters need no clearing, since only the counted ones are ever read.
// A stall on the output propagates to o_stall once the emitter has a further result
// queued behind the one waiting in the output register.

module case_insensitive_find_replace
    import cifr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire t_in                i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output t_out                    o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [CfgW-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [CfgW-1:0] r_pat_lo;
    logic [CfgW-1:0] r_pat_hi;
    logic [LenW-1:0] r_pat_len;
    logic [CfgW-1:0] r_rpl_lo;
    logic [CfgW-1:0] r_rpl_hi;
    logic [LenW-1:0] r_rpl_len;

    // Number of characters held back because they might still start a match.
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;

    t_chars          pat_chars;
    t_chars          rpl_chars;
    t_chars          line;
    logic [CntW-1:0] plen_used;
    logic [CntW-1:0] plen_m1;
    logic [CntW-1:0] rlen_used;
    logic            plen_zero;
    logic            pat_wr;
    logic            emit_ready;
    logic            accept;
    logic            match;
    logic [CntW-1:0] new_count;
    logic [CntW-1:0] lo;
    logic [CntW-1:0] n_total;
    t_job            job;
    logic            load;
    t_cell_ctl       cell_ctl;

    logic [Depth-1:0]            alive_q;
    logic [Depth-1:0]            alive_nx;
    logic [Depth-1:0][CharW-1:0] cell_char;

    assign pat_chars = t_chars'({r_pat_hi, r_pat_lo});
    assign rpl_chars = t_chars'({r_rpl_hi, r_rpl_lo});

    // Lengths in force: anything past the window depth is taken as the full depth.
    assign plen_used = (r_pat_len > LenW'(PatternMax)) ? CntW'(PatternMax) : r_pat_len;
    assign rlen_used = (r_rpl_len > LenW'(Depth)) ? CntW'(Depth) : r_rpl_len;
    assign plen_zero = (plen_used == '0);
    assign plen_m1   = plen_used - CntW'(1);

    // Any write to the pattern throws away what the window holds.
    always_comb begin
        pat_wr = 1'b0;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx)) inside
                REG_PAT_LO, REG_PAT_HI, REG_PAT_LEN: pat_wr = 1'b1;
                default:                              pat_wr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_rpl_lo  <= '0;
            r_rpl_hi  <= '0;
            r_rpl_len <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                REG_PAT_LEN: r_pat_len <= i_cfg_data[LenW-1:0];
                REG_RPL_LO:  r_rpl_lo  <= i_cfg_data;
                REG_RPL_HI:  r_rpl_hi  <= i_cfg_data;
                REG_RPL_LEN: r_rpl_len <= i_cfg_data[LenW-1:0];
                default: begin
                end
            endcase
        end
    end

    // A request is taken whenever the emitter can accept the work it produces.
    assign accept  = i_valid && emit_ready;
    assign o_stall = !emit_ready;

    // Row of cells. Cell k holds the character received k+1 requests ago and the flag
    // saying that the last k+1 characters spell the first k+1 pattern characters.
    // Every request shifts characters and flags one cell further along the row.
    assign line[0] = i_data.in_char;

    genvar k;
    generate
        for (k = 0; k < Depth; k++) begin : g_cell
            logic alive_prev;
            logic keep;

            if (k == 0) begin : g_head
                assign alive_prev = 1'b1;
            end else begin : g_body
                assign alive_prev = alive_q[k-1];
                assign line[k]    = cell_char[k-1];
            end

            // Only partial matches shorter than the pattern are kept in the row.
            assign keep = (CntW'(k + 1) < plen_used);

            cifr_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_char       (i_data.in_char),
                .i_char_prev  (line[k]),
                .i_alive_prev (alive_prev),
                .i_pat_char   (pat_chars[k]),
                .i_keep       (keep),
                .o_char       (cell_char[k]),
                .o_alive      (alive_q[k]),
                .o_alive_next (alive_nx[k])
            );
        end
    endgenerate

    // The longest surviving partial match is the new window; anything older than it
    // can no longer be part of a match and leaves, oldest first.
    always_comb begin
        new_count = '0;
        for (int j = 1; j < Depth; j++) begin
            if (alive_nx[j-1] && (CntW'(j) < plen_used)) begin
                new_count = CntW'(j);
            end
        end
    end

    assign match   = !plen_zero && alive_nx[plen_m1[IdxW-1:0]];
    assign n_total = r_count + CntW'(1);
    assign lo      = i_data.in_last ? '0 : new_count;

    // Work handed to the emitter: a run of window characters from the oldest down,
    // the replacement, or the empty end marker when the last request yields nothing.
    always_comb begin
        job.kind = SRC_WINDOW;
        job.idx  = r_count[IdxW-1:0];
        job.left = n_total - lo;
        job.last = i_data.in_last;
        if (match) begin
            job.idx = '0;
            if (rlen_used != '0) begin
                job.kind = SRC_REPL;
                job.left = rlen_used;
            end else if (i_data.in_last) begin
                job.kind = SRC_MARK;
                job.left = CntW'(1);
            end else begin
                job.left = '0;
            end
        end
    end

    assign load = accept && (job.left != '0);

    assign cell_ctl.shift = accept;
    assign cell_ctl.clear = pat_wr || (accept && (match || i_data.in_last));

    always_comb begin
        n_count = r_count;
        if (pat_wr) begin
            n_count = '0;
        end else if (accept) begin
            n_count = (match || i_data.in_last) ? '0 : new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    cifr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_job   (job),
        .i_line  (line),
        .i_repl  (rpl_chars),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    a_window_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count < plen_used))
        else $error("window holds as many characters as the pattern is long");

    a_window_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> alive_q[r_count[IdxW-1:0] - IdxW'(1)])
        else $error("held characters are not a partial match of the pattern");

    a_flush_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.in_last && !pat_wr) |=> (r_count == '0 && alive_q == '0))
        else $error("window not emptied after the final request of a stream");

endmodule

`default_nettype wire

// ----- bench/tb_case_insensitive_find_replace.sv -----
module tb_case_insensitive_find_replace;
    import cifr_pkg::*;

    // Indices past the end of the register map. Writes to them must leave everything alone.
    localparam logic [CfgIdxW-1:0] NoRegA = 3'd6;
    localparam logic [CfgIdxW-1:0] NoRegB = 3'd7;

    // Cycles allowed after the last expected result before the block is treated as idle.
    // A request may produce no result at all, so the block is given time to settle.
    localparam int QuietCycles = 32;
    localparam int RandomItems = 96;
    localparam int TimeLimit   = 4_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel, driven by the request driver.
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;

    // Output channel, accepted by the result monitor.
    logic o_valid;
    t_out o_data;
    logic i_stall = 1'b0;

    // Register write port, driven from the stimulus sequence.
    logic               i_cfg_we   = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx  = REG_PAT_LO;
    logic [CfgW-1:0]    i_cfg_data = '0;

    case_insensitive_find_replace dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Requests waiting to be driven, and the results still owed by the block.
    t_in  pending_text[$];
    t_out expected_text[$];

    int requests_queued = 0;
    int requests_taken  = 0;
    int results_seen    = 0;
    int markers_seen    = 0;
    int phases_run      = 0;
    int mismatches      = 0;

    // When set, neither side inserts gaps for the current phase.
    bit steady = 1'b0;
    int gap_left  = 0;
    int hold_left = 0;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the pending window.
    // ------------------------------------------------------------------
    logic [CfgW-1:0]  pat_lo_q  = '0;
    logic [CfgW-1:0]  pat_hi_q  = '0;
    logic [LenW-1:0]  pat_len_q = '0;
    logic [CfgW-1:0]  rpl_lo_q  = '0;
    logic [CfgW-1:0]  rpl_hi_q  = '0;
    logic [LenW-1:0]  rpl_len_q = '0;
    logic [CharW-1:0] held_chars [Depth];
    logic [CntW-1:0]  held_count = '0;

    // Results produced by the request currently being predicted.
    int step_results;

    // Only the letters A to Z are folded; every other byte compares exactly.
    function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] ch);
        if (ch >= "A" && ch <= "Z") begin
            return ch | 8'h20;
        end
        return ch;
    endfunction

    function automatic logic [CharW-1:0] char_at(input logic [CfgW-1:0] lo,
                                                 input logic [CfgW-1:0] hi, input int k);
        if (k < 8) begin
            return lo[8*k +: 8];
        end
        return hi[8*(k-8) +: 8];
    endfunction

    // True when the first count held characters agree with the start of the pattern.
    function automatic bit held_matches(input int count);
        for (int k = 0; k < count; k++) begin
            if (to_lower(held_chars[k]) != to_lower(char_at(pat_lo_q, pat_hi_q, k))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void owe_result(input logic [CharW-1:0] ch, input logic carries);
        t_out r;
        r.out_char  = ch;
        r.out_valid = carries;
        r.out_last  = 1'b0;
        expected_text.push_back(r);
        step_results++;
    endfunction

    // The oldest held character can no longer start a match, so it leaves as it came.
    function automatic void release_oldest();
        owe_result(held_chars[0], 1'b1);
        for (int k = 1; k < held_count; k++) begin
            held_chars[k-1] = held_chars[k];
        end
        held_count--;
    endfunction

    // Works out every result that one accepted request causes.
    function automatic void predict_request(input t_in req);
        int plen;
        int rlen;
        step_results = 0;
        plen = (pat_len_q > Depth) ? Depth : int'(pat_len_q);
        if (plen > PatternMax) begin
            plen = PatternMax;
        end
        if (plen == 0) begin
            // With no pattern the text simply passes through.
            held_count = '0;
            owe_result(req.in_char, 1'b1);
        end else begin
            if (held_count >= plen) begin
                held_count = '0;
            end
            held_chars[held_count[IdxW-1:0]] = req.in_char;
            held_count++;
            if (held_count == plen && held_matches(plen)) begin
                rlen = (rpl_len_q > 16) ? 16 : int'(rpl_len_q);
                for (int k = 0; k < rlen; k++) begin
                    owe_result(char_at(rpl_lo_q, rpl_hi_q, k), 1'b1);
                end
                held_count = '0;
            end else begin
                while (held_count > 0 && !held_matches(held_count)) begin
                    release_oldest();
                end
            end
        end
        if (req.in_last) begin
            while (held_count > 0) begin
                release_oldest();
            end
            // Nothing left to say, so the stream still gets an empty closing result.
            if (step_results == 0) begin
                owe_result('0, 1'b0);
            end
            expected_text[expected_text.size()-1].out_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected result char %02h valid %0b last %0b",
                                      got.out_char, got.out_valid, got.out_last));
        end else begin
            want = expected_text.pop_front();
            if (got.out_char !== want.out_char) begin
                report_mismatch($sformatf("result %0d: char %02h, expected %02h",
                                          results_seen, got.out_char, want.out_char));
            end
            if (got.out_valid !== want.out_valid) begin
                report_mismatch($sformatf("result %0d: valid flag %0b, expected %0b",
                                          results_seen, got.out_valid, want.out_valid));
            end
            if (got.out_last !== want.out_last) begin
                report_mismatch($sformatf("result %0d: last flag %0b, expected %0b",
                                          results_seen, got.out_last, want.out_last));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. A request is taken at an edge where valid is high and stall is low.
    // A new request is presented only once the previous one has gone, after a random gap.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_request(i_data);
                requests_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_text.size() > 0) begin
                    i_data   <= pending_text.pop_front();
                    i_valid  <= 1'b1;
                    gap_left = steady ? 0 : $urandom_range(0, 5);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. After each result it holds the output off for a random number
    // of cycles, so that stalls land on every part of the emitter's work.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                check_result(o_data);
                results_seen++;
                if (o_data.out_valid !== 1'b1) begin
                    markers_seen++;
                end
                hold_left = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_item(input logic [CharW-1:0] ch, input logic last);
        t_in r;
        r.in_char = ch;
        r.in_last = last;
        pending_text.push_back(r);
        requests_queued++;
    endfunction

    function automatic void queue_text(input string s, input bit with_last);
        for (int k = 0; k < s.len(); k++) begin
            queue_item(s[k], with_last && (k == s.len() - 1));
        end
    endfunction

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] res;
        res = '0;
        for (int k = 0; k < s.len() && k < 16; k++) begin
            res[8*k +: 8] = s[k];
        end
        return res;
    endfunction

    // Only the low five bits of a length register count; the rest carry junk.
    function automatic logic [CfgW-1:0] length_word(input int len);
        logic [CfgW-1:0] res;
        res = {$urandom(), $urandom()};
        res[LenW-1:0] = len[LenW-1:0];
        return res;
    endfunction

    // One register write per clock. The predictor copy is updated at once, which is safe
    // because registers are only written while nothing is in flight.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_PAT_LO: begin
                pat_lo_q   = val;
                held_count = '0;
            end
            REG_PAT_HI: begin
                pat_hi_q   = val;
                held_count = '0;
            end
            REG_PAT_LEN: begin
                pat_len_q  = val[LenW-1:0];
                held_count = '0;
            end
            REG_RPL_LO: begin
                rpl_lo_q = val;
            end
            REG_RPL_HI: begin
                rpl_hi_q = val;
            end
            REG_RPL_LEN: begin
                rpl_len_q = val[LenW-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_pattern(input logic [127:0] chars, input logic [CfgW-1:0] len_val);
        write_reg(REG_PAT_LO, chars[63:0]);
        write_reg(REG_PAT_HI, chars[127:64]);
        write_reg(REG_PAT_LEN, len_val);
    endtask

    task automatic load_replacement(input logic [127:0] chars, input logic [CfgW-1:0] len_val);
        write_reg(REG_RPL_LO, chars[63:0]);
        write_reg(REG_RPL_HI, chars[127:64]);
        write_reg(REG_RPL_LEN, len_val);
    endtask

    // Waits until every queued request has been taken and every result has come back,
    // then gives the block time to finish work that produces no result.
    task automatic wait_idle();
        while (requests_taken != requests_queued || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QuietCycles) @(posedge i_clk);
        phases_run++;
    endtask

    // Pattern characters lean on a few letters so that matches are common.
    function automatic logic [CharW-1:0] pick_pattern_char();
        if ($urandom_range(0, 9) < 7) begin
            return CharW'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 2));
        end
        return CharW'($urandom_range(0, 255));
    endfunction

    function automatic logic [CharW-1:0] flip_case(input logic [CharW-1:0] ch);
        if (((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) && $urandom_range(0, 1)) begin
            return ch ^ 8'h20;
        end
        return ch;
    endfunction

    // One random phase: fresh replacement registers and usually a fresh pattern, then a stream
    // made mostly of whole occurrences of the current pattern in random case, with broken prefixes and noise mixed in.
    task automatic random_phase(output int made);
        logic [127:0] chars;
        int           plen;
        int           cut;
        int           target;
        t_in          burst[$];
        t_in          r;
        if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 16; k++) begin
                chars[8*k +: 8] = pick_pattern_char();
            end
            case ($urandom_range(0, 9))
                0: plen = 0;
                1: plen = 16;
                2: plen = $urandom_range(17, 31);
                default: plen = $urandom_range(1, 4);
            endcase
            load_pattern(chars, length_word(plen));
        end
        chars = {$urandom(), $urandom(), $urandom(), $urandom()};
        load_replacement(chars, length_word(($urandom_range(0, 7) == 0) ?
                                            $urandom_range(17, 31) : $urandom_range(0, 16)));
        close_writes();
        steady = ($urandom_range(0, 3) == 0);

        plen   = (pat_len_q > 16) ? 16 : int'(pat_len_q);
        target = $urandom_range(8, 20);
        while (burst.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: cut = plen;
                6, 7: cut = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
                default: cut = 0;
            endcase
            for (int k = 0; k < cut; k++) begin
                r.in_char = flip_case(char_at(pat_lo_q, pat_hi_q, k));
                r.in_last = ($urandom_range(0, 15) == 0);
                burst.push_back(r);
            end
            if (cut < plen || plen == 0 || $urandom_range(0, 2) == 0) begin
                r.in_char = $urandom_range(0, 1) ? CharW'($urandom_range(0, 255))
                                                 : pick_pattern_char();
                r.in_last = ($urandom_range(0, 15) == 0);
                burst.push_back(r);
            end
        end
        // Most streams close with a last request; the others leave characters waiting.
        if ($urandom_range(0, 3) != 0) begin
            burst[burst.size()-1].in_last = 1'b1;
        end
        foreach (burst[k]) begin
            queue_item(burst[k].in_char, burst[k].in_last);
        end
        made = burst.size();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, random phases, then the verdict.
    // ------------------------------------------------------------------
    initial begin
        int made;
        int random_total;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // After reset the pattern is empty, so the extreme bytes pass straight through.
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b1);
        wait_idle();

        // A short pattern matched with its letters in the opposite case.
        load_pattern(pack_text("aBc"), CfgW'(3));
        load_replacement(pack_text("XY"), CfgW'(2));
        close_writes();
        queue_text("AbC@", 1'b1);
        wait_idle();

        // An empty replacement that swallows the whole stream leaves only the closing marker.
        load_pattern(pack_text("ab"), CfgW'(2));
        write_reg(REG_RPL_LEN, '0);
        close_writes();
        queue_text("aB", 1'b1);
        wait_idle();

        // A character left in the window is thrown away when the pattern is rewritten.
        queue_text("a", 1'b0);
        wait_idle();
        load_pattern(pack_text("ba"), CfgW'(2));
        close_writes();
        queue_text("b", 1'b1);
        wait_idle();

        // Writes past the register map do nothing. Both lengths are set beyond sixteen,
        // so the longest pattern and replacement are the ones in use.
        write_reg(NoRegA, {$urandom(), $urandom()});
        write_reg(NoRegB, {$urandom(), $urandom()});
        load_pattern(pack_text("AbcdEfghIjklMnoP"), CfgW'(31));
        load_replacement(pack_text("0123456789]^_`{~"), CfgW'(20));
        write_reg(NoRegA, '0);
        close_writes();
        queue_text("aBCDeFGHiJKLmNOp", 1'b1);
        wait_idle();

        random_total = 0;
        while (random_total < RandomItems) begin
            random_phase(made);
            random_total += made;
        end

        // Give any stray result a chance to show up before judging.
        repeat (QuietCycles) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_text.size()));
        end

        $display("Summary: %0d requests over %0d phases, %0d random.",
                 requests_taken, phases_run, random_total);
        $display("Summary: %0d results checked, %0d of them empty closing markers.",
                 results_seen, markers_seen);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: the slowest correct run finishes well inside this time.
    initial begin
        #(TimeLimit);
        $display("Timeout: %0d of %0d requests taken, %0d results outstanding.",
                 requests_taken, requests_queued, expected_text.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
